/* rtl/core/six_step_commutation_sequencer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Six-step commutation sequencer assertion macros
// Shared concurrent assertion forms for the sequencer checker.
// ----------------------------------------------------------------------------
`ifndef SIX_STEP_COMMUTATION_SEQUENCER_UNIT_MACROS_SVH
`define SIX_STEP_COMMUTATION_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define SSC_ASSERT_NOW(label, clk, dis, pre, post) \
    label: assert property (@(posedge clk) disable iff (dis) (pre) |-> (post)) \
        else $error("sequencer assertion failed");

// Next-cycle implication, disabled while dis is high.
`define SSC_ASSERT_NEXT(label, clk, dis, pre, post) \
    label: assert property (@(posedge clk) disable iff (dis) (pre) |=> (post)) \
        else $error("sequencer assertion failed");

`endif

/* rtl/core/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// Six-step commutation sequencer package
// Widths, register indexes, reset values, state types and sector table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int TickW   = 32;
    localparam int PeriodW = 10;
    localparam int DebW    = 10;
    localparam int IncW    = 8;
    localparam int LimW    = 10;
    localparam int SecW    = 3;
    localparam int GateW   = 3;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 10;

    localparam logic [CfgIdxW-1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_INCREMENT = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_LIMIT     = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_START     = 2'd3;

    localparam logic [DebW-1:0]    RST_DEBOUNCE  = 10'd100;
    localparam logic [IncW-1:0]    RST_INCREMENT = 8'd50;
    localparam logic [LimW-1:0]    RST_LIMIT     = 10'd1000;
    localparam logic [PeriodW-1:0] RST_START     = 10'd500;

    localparam logic [SecW-1:0] SEC_1 = 3'd1;
    localparam logic [SecW-1:0] SEC_2 = 3'd2;
    localparam logic [SecW-1:0] SEC_3 = 3'd3;
    localparam logic [SecW-1:0] SEC_4 = 3'd4;
    localparam logic [SecW-1:0] SEC_5 = 3'd5;
    localparam logic [SecW-1:0] SEC_6 = 3'd6;

    localparam logic [GateW-1:0] PH_U = 3'b001;
    localparam logic [GateW-1:0] PH_V = 3'b010;
    localparam logic [GateW-1:0] PH_W = 3'b100;

    typedef struct packed {
        logic [DebW-1:0] debounce;
        logic [IncW-1:0] increment;
        logic [LimW-1:0] limit;
    } t_cfg;

    typedef struct packed {
        logic [TickW-1:0]   tick;
        logic [TickW-1:0]   btn_stamp;
        logic               btn_stable;
        logic [TickW-1:0]   step_stamp;
        logic [PeriodW-1:0] period;
        logic [SecW-1:0]    sector;
        logic [GateW-1:0]   high;
        logic [GateW-1:0]   low;
        logic               led;
    } t_state;

    typedef struct packed {
        logic [GateW-1:0] high;
        logic [GateW-1:0] low;
        logic [SecW-1:0]  next;
    } t_sector_entry;

    function automatic t_sector_entry sector_lookup(input logic [SecW-1:0] sec);
        t_sector_entry e;
        case (sec)
            SEC_2: e = '{high: PH_V, low: PH_W, next: SEC_3};
            SEC_3: e = '{high: PH_V, low: PH_U, next: SEC_4};
            SEC_4: e = '{high: PH_W, low: PH_U, next: SEC_5};
            SEC_5: e = '{high: PH_W, low: PH_V, next: SEC_6};
            SEC_6: e = '{high: PH_U, low: PH_V, next: SEC_1};
            default: e = '{high: PH_U, low: PH_W, next: SEC_2};
        endcase
        return e;
    endfunction

endpackage

/* rtl/core/ssc_if.sv */
// ----------------------------------------------------------------------------
// Six-step commutation sequencer stream interfaces
// Valid/ready channels for button samples and commutation results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ssc_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink (input valid, input button_level, output ready);
endinterface

interface ssc_out_if
    import ssc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [GateW-1:0]   high_gates;
    logic [GateW-1:0]   low_gates;
    logic               led_level;
    logic               step_taken;
    logic [PeriodW-1:0] period_now;

    modport source (output valid, output high_gates, output low_gates, output led_level,
                    output step_taken, output period_now, input ready);
    modport sink (input valid, input high_gates, input low_gates, input led_level,
                  input step_taken, input period_now, output ready);
endinterface

/* rtl/core/ssc_step_logic.sv */
// ----------------------------------------------------------------------------
// Six-step commutation sequencer tick logic
// Debounce, period update and commutation step for one tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssc_step_logic
    import ssc_pkg::*;
(
    input  t_cfg   i_cfg,
    input  t_state i_state,
    input  logic   i_level,
    output t_state o_state,
    output logic   o_stepped
);

    logic [TickW-1:0]   tick_n;
    logic [TickW-1:0]   btn_elapsed;
    logic [TickW-1:0]   step_elapsed;
    logic               btn_change;
    logic [PeriodW:0]   period_sum;
    logic [PeriodW-1:0] period_cand;
    logic [PeriodW-1:0] period_n;
    t_sector_entry      sec_e;

    always_comb begin
        tick_n      = i_state.tick + 1'b1;
        btn_elapsed = tick_n - i_state.btn_stamp;
        btn_change  = (i_level != i_state.btn_stable) &&
                      (btn_elapsed >= {{(TickW-DebW){1'b0}}, i_cfg.debounce});

        period_sum  = {1'b0, i_state.period} + {{(PeriodW+1-IncW){1'b0}}, i_cfg.increment};
        period_cand = (period_sum > {1'b0, i_cfg.limit})
                    ? {{(PeriodW-IncW){1'b0}}, i_cfg.increment}
                    : period_sum[PeriodW-1:0];
        period_n    = (btn_change && !i_level) ? period_cand : i_state.period;

        step_elapsed = tick_n - i_state.step_stamp;
        o_stepped    = step_elapsed >= {{(TickW-PeriodW){1'b0}}, period_n};
        sec_e        = sector_lookup(i_state.sector);

        o_state        = i_state;
        o_state.tick   = tick_n;
        o_state.period = period_n;
        if (btn_change) begin
            o_state.btn_stable = i_level;
            o_state.btn_stamp  = tick_n;
        end
        if (o_stepped) begin
            o_state.step_stamp = tick_n;
            o_state.led        = ~i_state.led;
            o_state.high       = sec_e.high;
            o_state.low        = sec_e.low;
            o_state.sector     = sec_e.next;
        end
    end

endmodule

/* rtl/core/six_step_commutation_sequencer_unit.sv */
// Flow: an accepted input transaction is held in the input register and passes
// through the tick logic into the result register once that register is free.
// Throughput: one transaction per cycle while the result side is not stalled; the
// tick logic between the input register and the result register is combinational.
// Reset: synchronous, active low; configuration registers return to their reset values,
// state to tick zero, sector one, gates off, LED off, period 500.
// ----------------------------------------------------------------------------
// Six-step commutation sequencer top level
// Tick-driven button debounce, period control and six-step gate sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module six_step_commutation_sequencer_unit
    import ssc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data,
    ssc_in_if.sink             i_btn,
    ssc_out_if.source          o_res
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    logic   n_stepped;

    logic   r_in_valid;
    logic   r_in_level;
    logic   r_out_valid;
    logic [GateW-1:0]   r_out_high;
    logic [GateW-1:0]   r_out_low;
    logic               r_out_led;
    logic               r_out_step;
    logic [PeriodW-1:0] r_out_period;

    logic   out_free;
    logic   advance;

    assign out_free    = !r_out_valid || o_res.ready;
    assign advance     = r_in_valid && out_free;
    assign i_btn.ready = !r_in_valid || out_free;

    ssc_step_logic u_step (
        .i_cfg     (r_cfg),
        .i_state   (r_state),
        .i_level   (r_in_level),
        .o_state   (n_state),
        .o_stepped (n_stepped)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce  <= RST_DEBOUNCE;
            r_cfg.increment <= RST_INCREMENT;
            r_cfg.limit     <= RST_LIMIT;
            r_state         <= '{tick: '0, btn_stamp: '0, btn_stable: 1'b1,
                                 step_stamp: '0, period: RST_START, sector: SEC_1,
                                 high: '0, low: '0, led: 1'b0};
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DEBOUNCE:  r_cfg.debounce  <= i_cfg_data[DebW-1:0];
                    REG_INCREMENT: r_cfg.increment <= i_cfg_data[IncW-1:0];
                    REG_LIMIT:     r_cfg.limit     <= i_cfg_data[LimW-1:0];
                    REG_START:     r_state.period  <= i_cfg_data[PeriodW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_btn.ready) begin
                r_in_valid <= i_btn.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_btn.valid && i_btn.ready) begin
            r_in_level <= i_btn.button_level;
        end
        if (advance) begin
            r_out_high   <= n_state.high;
            r_out_low    <= n_state.low;
            r_out_led    <= n_state.led;
            r_out_step   <= n_stepped;
            r_out_period <= n_state.period;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.high_gates = r_out_high;
    assign o_res.low_gates  = r_out_low;
    assign o_res.led_level  = r_out_led;
    assign o_res.step_taken = r_out_step;
    assign o_res.period_now = r_out_period;

endmodule

/* rtl/core/ssc_checker.sv */
// ----------------------------------------------------------------------------
// Six-step commutation sequencer port checker
// Port-level checks on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "six_step_commutation_sequencer_unit_macros.svh"

module ssc_checker
    import ssc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input logic [GateW-1:0]   i_high_gates,
    input logic [GateW-1:0]   i_low_gates,
    input logic               i_led_level,
    input logic               i_step_taken,
    input logic [PeriodW-1:0] i_period_now
);

    `SSC_ASSERT_NEXT(a_res_hold, i_clk, !i_rst_n,
        i_res_valid && !i_res_ready,
        i_res_valid && $stable({i_high_gates, i_low_gates, i_led_level,
                                i_step_taken, i_period_now}))
    `SSC_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !i_res_valid)
    `SSC_ASSERT_NOW(a_no_shoot, i_clk, !i_rst_n, i_res_valid,
        (i_high_gates & i_low_gates) == '0)
    `SSC_ASSERT_NOW(a_step_pattern, i_clk, !i_rst_n, i_res_valid && i_step_taken,
        $onehot(i_high_gates) && $onehot(i_low_gates))

endmodule

bind six_step_commutation_sequencer_unit ssc_checker u_ssc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_high_gates (o_res.high_gates),
    .i_low_gates  (o_res.low_gates),
    .i_led_level  (o_res.led_level),
    .i_step_taken (o_res.step_taken),
    .i_period_now (o_res.period_now)
);
